>>> sv/adsr2v_pkg.sv
package adsr2v_pkg;

	localparam int SINE_TABLE_DEPTH_DEF = 1024;
	localparam int PHASE_WIDTH_DEF = 32;
	localparam int INDEX_WIDTH_DEF = 20;

	localparam int STEP_W = 32;
	localparam int LEN_W = 20;
	localparam int SUS_W = 16;
	localparam int AMP_W = 14;
	localparam int SAMPLE_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [SUS_W:0] VOL_ONE = 17'd32768;
	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NOTE_LENGTH       = 3'd0,
		REG_ATTACK_LENGTH     = 3'd1,
		REG_DECAY_LENGTH      = 3'd2,
		REG_RELEASE_LENGTH    = 3'd3,
		REG_SUSTAIN_LEVEL     = 3'd4,
		REG_MELODY_AMPLITUDE  = 3'd5,
		REG_HARMONY_AMPLITUDE = 3'd6
	} cfg_reg_t;

	localparam logic [LEN_W-1:0] NOTE_LENGTH_RST = 20'd22050;
	localparam logic [LEN_W-1:0] ATTACK_LENGTH_RST = 20'd2205;
	localparam logic [LEN_W-1:0] DECAY_LENGTH_RST = 20'd4410;
	localparam logic [LEN_W-1:0] RELEASE_LENGTH_RST = 20'd6615;
	localparam logic [SUS_W-1:0] SUSTAIN_LEVEL_RST = 16'd22938;
	localparam logic [AMP_W-1:0] MELODY_AMPLITUDE_RST = 14'd8000;
	localparam logic [AMP_W-1:0] HARMONY_AMPLITUDE_RST = 14'd6000;

	typedef struct packed {
		logic [STEP_W-1:0] melody_step;
		logic [STEP_W-1:0] harmony_step;
		logic              note_start;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_sample;
		logic signed [SAMPLE_W-1:0] right_sample;
		logic                       last_of_note;
	} out_item_t;

	// one sine table entry, q1.15, built by quarter symmetry and a q30 taylor series
	function automatic logic signed [SAMPLE_W-1:0] sine_entry(input logic [63:0] k,
			input int aw);
		logic [63:0] depth;
		logic [63:0] quad;
		logic [63:0] rem;
		logic [63:0] m;
		logic [63:0] y;
		logic [63:0] y2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		depth = 64'd1 << aw;
		quad = (k << 2) >> aw;
		rem = (k << 2) & (depth - 64'd1);
		m = quad[0] ? depth - rem : rem;
		y = (PI_HALF_Q30 * m) >> aw;
		y2 = (y * y) >> 30;
		t = Q30_ONE - y2 / 110;
		t = Q30_ONE - ((y2 * t) >> 30) / 72;
		t = Q30_ONE - ((y2 * t) >> 30) / 42;
		t = Q30_ONE - ((y2 * t) >> 30) / 20;
		t = Q30_ONE - ((y2 * t) >> 30) / 6;
		s = (y * t) >> 30;
		v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return quad[1] ? -SAMPLE_W'(v) : SAMPLE_W'(v);
	endfunction

endpackage

>>> sv/adsr_two_voice_tone_generator_core.sv
// two-voice sine tone generator with a linear adsr envelope, one sample per item
// steps: table reads, the two amplitude products and their sum; in attack, decay or
// release the envelope product, a restoring divide and the volume; then the mix times
// the volume; an ended note gives silence. One item at a time, stalled until idle
// reset (arst_n low): registers to defaults, index and both phases to zero, no result
module adsr_two_voice_tone_generator_core #(
	parameter int SINE_TABLE_DEPTH = adsr2v_pkg::SINE_TABLE_DEPTH_DEF,
	parameter int PHASE_WIDTH = adsr2v_pkg::PHASE_WIDTH_DEF,
	parameter int INDEX_WIDTH = adsr2v_pkg::INDEX_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  adsr2v_pkg::in_item_t                 in_item,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output adsr2v_pkg::out_item_t                out_item,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [adsr2v_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [adsr2v_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import adsr2v_pkg::*;

	// table depth is a power of two; the top phase bits address it
	localparam int AW = $clog2(SINE_TABLE_DEPTH);
	// compare width covering both the index and the note length
	localparam int CW = (INDEX_WIDTH > LEN_W) ? INDEX_WIDTH : LEN_W;
	localparam int MA_W = 33;
	localparam int MB_W = 18;
	localparam int MP_W = MA_W + MB_W;
	localparam int DVD_W = LEN_W + SUS_W;
	localparam int CNT_W = $clog2(DVD_W);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVD_W - 1);
	localparam logic [INDEX_WIDTH-1:0] IDX_MAX = '1;

	typedef logic signed [SAMPLE_W-1:0] rom_t [SINE_TABLE_DEPTH];

	function automatic rom_t build_rom();
		rom_t tab;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			tab[k] = sine_entry(64'(k), AW);
		end
		return tab;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_RDM  = 10'b00_0000_0010,
		ST_MULM = 10'b00_0000_0100,
		ST_MULH = 10'b00_0000_1000,
		ST_SUM  = 10'b00_0001_0000,
		ST_ENV  = 10'b00_0010_0000,
		ST_DIV  = 10'b00_0100_0000,
		ST_VOL  = 10'b00_1000_0000,
		ST_FIN  = 10'b01_0000_0000,
		ST_OUT  = 10'b10_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		RG_ATTACK,
		RG_DECAY,
		RG_RELEASE
	} region_t;

	state_t state_q;
	region_t region_q;

	// configuration registers
	logic [LEN_W-1:0] note_len_q;
	logic [LEN_W-1:0] att_len_q;
	logic [LEN_W-1:0] dec_len_q;
	logic [LEN_W-1:0] rel_len_q;
	logic [SUS_W-1:0] sus_lvl_q;
	logic [AMP_W-1:0] mel_amp_q;
	logic [AMP_W-1:0] har_amp_q;

	// voice and note state
	logic [INDEX_WIDTH-1:0] idx_q;
	logic [PHASE_WIDTH-1:0] mel_phase_q;
	logic [PHASE_WIDTH-1:0] har_phase_q;

	// per-item working registers
	logic [AW-1:0] mel_addr_q;
	logic [AW-1:0] har_addr_q;
	logic signed [SAMPLE_W-1:0] rom_q;
	logic signed [MP_W-1:0] prod_q;
	logic signed [31:0] mix_q;
	logic [SUS_W:0] vol_q;
	logic active_q;
	logic [LEN_W-1:0] den_q;
	logic [DVD_W-1:0] dvd_q;
	logic [LEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic out_valid_q;
	out_item_t out_q;

	logic accept;
	logic out_free;
	logic [INDEX_WIDTH-1:0] idx_base;
	logic [PHASE_WIDTH-1:0] mel_base;
	logic [PHASE_WIDTH-1:0] har_base;
	logic [CW-1:0] idx_ext;
	logic [CW-1:0] len_ext;
	logic [LEN_W-1:0] env_i;
	logic [SUS_W:0] sus_eff;
	logic [LEN_W:0] att_dec_end;
	logic signed [LEN_W+1:0] rel_start;
	logic signed [MA_W-1:0] mult_a;
	logic signed [MB_W-1:0] mult_b;
	logic signed [MP_W-1:0] mult_p;
	logic [LEN_W:0] div_trial;
	logic div_ge;
	logic signed [MP_W-1:0] rnd;
	logic signed [MP_W-31:0] scaled;
	logic signed [SAMPLE_W-1:0] sample;
	logic last_hit;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item = out_q;
	assign out_free = !out_valid_q || !out_stall;

	// note start restarts the index and both phases before this sample
	assign idx_base = in_item.note_start ? '0 : idx_q;
	assign mel_base = in_item.note_start ? '0 : mel_phase_q;
	assign har_base = in_item.note_start ? '0 : har_phase_q;

	assign idx_ext = CW'(idx_q);
	assign len_ext = CW'(note_len_q);
	// while the note plays the index is below the note length, so it fits
	assign env_i = idx_ext[LEN_W-1:0];
	assign sus_eff = ({1'b0, sus_lvl_q} > VOL_ONE) ? VOL_ONE : {1'b0, sus_lvl_q};
	assign att_dec_end = {1'b0, att_len_q} + {1'b0, dec_len_q};
	// release start may lie before zero when release outlasts the note
	assign rel_start = $signed({2'b00, note_len_q}) - $signed({2'b00, rel_len_q});

	// shared multiplier operand select
	always_comb begin
		mult_a = '0;
		mult_b = '0;
		case (state_q)
			ST_MULM: begin
				mult_a = MA_W'(signed'({1'b0, mel_amp_q}));
				mult_b = MB_W'(rom_q);
			end
			ST_MULH: begin
				mult_a = MA_W'(signed'({1'b0, har_amp_q}));
				mult_b = MB_W'(rom_q);
			end
			ST_ENV: begin
				case (region_q)
					RG_ATTACK: begin
						mult_a = MA_W'(signed'({1'b0, env_i}));
						mult_b = MB_W'(signed'({1'b0, VOL_ONE}));
					end
					RG_DECAY: begin
						mult_a = MA_W'(signed'({1'b0, env_i - att_len_q}));
						mult_b = MB_W'(signed'({1'b0, VOL_ONE - sus_eff}));
					end
					default: begin
						mult_a = MA_W'(signed'({1'b0, note_len_q - env_i}));
						mult_b = MB_W'(signed'({1'b0, sus_eff}));
					end
				endcase
			end
			ST_FIN: begin
				mult_a = MA_W'(mix_q);
				mult_b = MB_W'(signed'({1'b0, vol_q}));
			end
			default: begin
				mult_a = '0;
				mult_b = '0;
			end
		endcase
	end

	assign mult_p = mult_a * mult_b;

	// one restoring division step per cycle
	assign div_trial = {rem_q, dvd_q[DVD_W-1]} - {1'b0, den_q};
	assign div_ge = !div_trial[LEN_W] || rem_q[LEN_W-1];

	// divide by 2^30 toward zero, then clamp to 16 bits
	assign rnd = prod_q + (prod_q[MP_W-1] ? MP_W'((64'd1 << 30) - 64'd1) : '0);
	assign scaled = rnd[MP_W-1:30];
	always_comb begin
		if (scaled > (MP_W-30)'(32767)) begin
			sample = 16'sh7fff;
		end else if (scaled < -(MP_W-30)'(32768)) begin
			sample = -16'sh8000;
		end else begin
			sample = scaled[SAMPLE_W-1:0];
		end
	end

	assign last_hit = ({1'b0, idx_ext} + (CW+1)'(1)) == {1'b0, len_ext};

	// configuration writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_len_q <= NOTE_LENGTH_RST;
			att_len_q <= ATTACK_LENGTH_RST;
			dec_len_q <= DECAY_LENGTH_RST;
			rel_len_q <= RELEASE_LENGTH_RST;
			sus_lvl_q <= SUSTAIN_LEVEL_RST;
			mel_amp_q <= MELODY_AMPLITUDE_RST;
			har_amp_q <= HARMONY_AMPLITUDE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_NOTE_LENGTH: note_len_q <= cfg_data;
				REG_ATTACK_LENGTH: att_len_q <= cfg_data;
				REG_DECAY_LENGTH: dec_len_q <= cfg_data;
				REG_RELEASE_LENGTH: rel_len_q <= cfg_data;
				REG_SUSTAIN_LEVEL: sus_lvl_q <= cfg_data[SUS_W-1:0];
				REG_MELODY_AMPLITUDE: mel_amp_q <= cfg_data[AMP_W-1:0];
				REG_HARMONY_AMPLITUDE: har_amp_q <= cfg_data[AMP_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			mel_phase_q <= '0;
			har_phase_q <= '0;
			out_valid_q <= 1'b0;
			active_q <= 1'b0;
			cnt_q <= '0;
			region_q <= RG_ATTACK;
		end else begin
			// result taken and no new one this cycle
			if (out_valid_q && !out_stall && !(state_q == ST_OUT && out_free)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// phases advance now; the table reads use the old values
						idx_q <= idx_base;
						mel_phase_q <= mel_base + PHASE_WIDTH'(in_item.melody_step);
						har_phase_q <= har_base + PHASE_WIDTH'(in_item.harmony_step);
						active_q <= CW'(idx_base) < len_ext;
						state_q <= (CW'(idx_base) < len_ext) ? ST_RDM : ST_OUT;
					end
				end
				ST_RDM: state_q <= ST_MULM;
				ST_MULM: state_q <= ST_MULH;
				ST_MULH: state_q <= ST_SUM;
				ST_SUM: begin
					// pick the envelope stage; sustain and zero release need no divide
					if (env_i < att_len_q) begin
						region_q <= RG_ATTACK;
						state_q <= ST_ENV;
					end else if ({1'b0, env_i} < att_dec_end) begin
						region_q <= RG_DECAY;
						state_q <= ST_ENV;
					end else if ($signed({2'b00, env_i}) < rel_start) begin
						state_q <= ST_FIN;
					end else if (rel_len_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						region_q <= RG_RELEASE;
						state_q <= ST_ENV;
					end
				end
				ST_ENV: begin
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == DIV_LAST) begin
						state_q <= ST_VOL;
					end
				end
				ST_VOL: state_q <= ST_FIN;
				ST_FIN: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (active_q && idx_ext < CW'(IDX_MAX)) begin
							idx_q <= idx_q + INDEX_WIDTH'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mel_addr_q <= mel_base[PHASE_WIDTH-1 -: AW];
				har_addr_q <= har_base[PHASE_WIDTH-1 -: AW];
			end
			ST_RDM: rom_q <= SINE_ROM[mel_addr_q];
			ST_MULM: begin
				prod_q <= mult_p;
				rom_q <= SINE_ROM[har_addr_q];
			end
			ST_MULH: begin
				mix_q <= prod_q[31:0];
				prod_q <= mult_p;
			end
			ST_SUM: begin
				mix_q <= mix_q + prod_q[31:0];
				// sustain level, or silence for a zero release
				vol_q <= (rel_len_q == '0 && !($signed({2'b00, env_i}) < rel_start))
					? '0 : sus_eff;
				case (1'b1)
					(env_i < att_len_q): den_q <= att_len_q;
					({1'b0, env_i} < att_dec_end): den_q <= dec_len_q;
					default: den_q <= rel_len_q;
				endcase
			end
			ST_ENV: begin
				dvd_q <= mult_p[DVD_W-1:0];
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= div_ge ? div_trial[LEN_W-1:0] : {rem_q[LEN_W-2:0], dvd_q[DVD_W-1]};
				dvd_q <= {dvd_q[DVD_W-2:0], div_ge};
			end
			ST_VOL: begin
				if (region_q == RG_DECAY) begin
					vol_q <= VOL_ONE - dvd_q[SUS_W:0];
				end else begin
					vol_q <= dvd_q[SUS_W:0];
				end
			end
			ST_FIN: prod_q <= mult_p;
			ST_OUT: begin
				if (out_free) begin
					out_q.left_sample <= active_q ? sample : '0;
					out_q.right_sample <= active_q ? sample : '0;
					out_q.last_of_note <= active_q && last_hit;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> test/tb_adsr_two_voice_tone_generator_core.sv
module tb_adsr_two_voice_tone_generator_core;
	timeunit 1ns;
	timeprecision 1ps;

	import adsr2v_pkg::*;

	// index past the last register, writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int SETTLE_CYCLES = 50;
	localparam int TABLE_DEPTH = 1024;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	adsr_two_voice_tone_generator_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// one line of the directed script: a register write or a sample tick
	typedef struct {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] data;
		in_item_t             tick;
		bit                   typed;
		out_item_t            want;
	} script_row_t;

	// shadow copy of the block: registers, note position and both oscillators
	logic [CFG_DATA_W-1:0] shadow_reg [0:6];
	logic [LEN_W-1:0]      note_pos;
	logic [STEP_W-1:0]     mel_acc;
	logic [STEP_W-1:0]     har_acc;
	logic signed [15:0]    sine_tab [0:TABLE_DEPTH-1];

	out_item_t   samples_due [$];
	bit          typed_due [$];
	out_item_t   typed_want [$];
	script_row_t script [$];
	int          errors;
	bit          calm;

	// 100 MHz clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// quarter-wave sine value, q30 taylor series then rounded into q1.15
	function automatic logic signed [15:0] quarter_sine(int k);
		logic [63:0] quad, rem, m, y, y2, t, s, v;
		quad = (64'(k) * 4) / TABLE_DEPTH;
		rem = (64'(k) * 4) % TABLE_DEPTH;
		m = quad[0] ? TABLE_DEPTH - rem : rem;
		y = (64'd1686629713 * m) / TABLE_DEPTH;
		y2 = (y * y) >> 30;
		t = (64'd1 << 30) - y2 / 110;
		t = (64'd1 << 30) - ((y2 * t) >> 30) / 72;
		t = (64'd1 << 30) - ((y2 * t) >> 30) / 42;
		t = (64'd1 << 30) - ((y2 * t) >> 30) / 20;
		t = (64'd1 << 30) - ((y2 * t) >> 30) / 6;
		s = (y * t) >> 30;
		v = (s * 32767 + (64'd1 << 29)) >> 30;
		if (v > 32767) begin
			v = 32767;
		end
		return quad >= 2 ? -16'(v) : 16'(v);
	endfunction

	// linear adsr volume in q1.15 for a position inside the note
	function automatic longint adsr_volume(longint i);
		longint n, a, d, r, s;
		n = shadow_reg[REG_NOTE_LENGTH];
		a = shadow_reg[REG_ATTACK_LENGTH];
		d = shadow_reg[REG_DECAY_LENGTH];
		r = shadow_reg[REG_RELEASE_LENGTH];
		s = shadow_reg[REG_SUSTAIN_LEVEL] > 32768 ? 32768 : shadow_reg[REG_SUSTAIN_LEVEL];
		if (i < a) begin
			return (i * 32768) / a;
		end
		if (i < a + d) begin
			return 32768 - ((i - a) * (32768 - s)) / d;
		end
		if (i < n - r) begin
			return s;
		end
		if (r == 0 || i >= n) begin
			return 0;
		end
		return (s * (n - i)) / r;
	endfunction

	// next mixed sample for one tick, advancing the shadow state
	function automatic out_item_t mix_tick(in_item_t tick);
		out_item_t res;
		longint n, mix, smp;
		n = shadow_reg[REG_NOTE_LENGTH];
		smp = 0;
		res.last_of_note = 1'b0;
		if (tick.note_start) begin
			note_pos = '0;
			mel_acc = '0;
			har_acc = '0;
		end
		if (longint'(note_pos) < n) begin
			mix = longint'(shadow_reg[REG_MELODY_AMPLITUDE]) * sine_tab[mel_acc[31:22]]
				+ longint'(shadow_reg[REG_HARMONY_AMPLITUDE]) * sine_tab[har_acc[31:22]];
			smp = (mix * adsr_volume(note_pos)) / (longint'(1) << 30);
			if (smp > 32767) begin
				smp = 32767;
			end
			if (smp < -32768) begin
				smp = -32768;
			end
			res.last_of_note = (longint'(note_pos) == n - 1);
		end
		res.left_sample = 16'(smp);
		res.right_sample = 16'(smp);
		mel_acc = mel_acc + tick.melody_step;
		har_acc = har_acc + tick.harmony_step;
		if (longint'(note_pos) < n && note_pos != '1) begin
			note_pos = note_pos + 1'b1;
		end
		return res;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// accept side predicts, result side compares against the oldest expectation
	always @(posedge clk) begin
		out_item_t due;
		out_item_t guess;
		if (arst_n && out_valid && !out_stall) begin
			if (samples_due.size() == 0) begin
				report("unexpected sample", 32'(out_item.left_sample), '0);
			end else begin
				due = samples_due.pop_front();
				if (out_item.left_sample !== due.left_sample) begin
					report("left_sample", 32'(out_item.left_sample), 32'(due.left_sample));
				end
				if (out_item.right_sample !== due.right_sample) begin
					report("right_sample", 32'(out_item.right_sample), 32'(due.right_sample));
				end
				if (out_item.last_of_note !== due.last_of_note) begin
					report("last_of_note", 32'(out_item.last_of_note), 32'(due.last_of_note));
				end
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			guess = mix_tick(in_item);
			if (typed_due.pop_front()) begin
				guess = typed_want.pop_front();
			end
			samples_due.push_back(guess);
		end
	end

	// result side backpressure, off during calm stretches
	always @(negedge clk) begin
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 36);
	end

	// hands one tick to the block; valid stays up across back-to-back items
	task automatic send_tick(in_item_t tick, bit typed, out_item_t want);
		@(negedge clk);
		if (!calm && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		typed_due.push_back(typed);
		if (typed) begin
			typed_want.push_back(want);
		end
		in_valid <= 1'b1;
		in_item <= tick;
		do @(posedge clk); while (in_stall);
	endtask

	// sender holds off until every sample is back and the pipeline is empty
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (samples_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SUSTAIN_LEVEL: begin
				shadow_reg[idx] = data & 20'hffff;
			end
			REG_MELODY_AMPLITUDE, REG_HARMONY_AMPLITUDE: begin
				shadow_reg[idx] = data & 20'h3fff;
			end
			REG_UNUSED: begin
			end
			default: begin
				shadow_reg[idx] = data;
			end
		endcase
	endtask

	function automatic void cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		script_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.data = data;
		script.push_back(row);
	endfunction

	function automatic void tick_row(logic [31:0] ms, logic [31:0] hs, bit start,
			bit typed, logic signed [15:0] smp, bit last);
		script_row_t row;
		row = '{default: '0};
		row.tick = '{melody_step: ms, harmony_step: hs, note_start: start};
		row.typed = typed;
		row.want = '{left_sample: smp, right_sample: smp, last_of_note: last};
		script.push_back(row);
	endfunction

	// random register set; lengths mostly short so every stage is reached
	function automatic logic [CFG_DATA_W-1:0] pick_len();
		int pick;
		pick = $urandom_range(99);
		if (pick < 8) begin
			return '0;
		end
		if (pick < 12) begin
			return '1;
		end
		return CFG_DATA_W'($urandom_range(0, 40));
	endfunction

	initial begin
		in_item_t tick;
		out_item_t none;
		bit in_cfg;
		int note_left;
		errors = 0;
		calm = 1'b0;
		none = '0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			sine_tab[k] = quarter_sine(k);
		end
		shadow_reg[REG_NOTE_LENGTH] = 22050;
		shadow_reg[REG_ATTACK_LENGTH] = 2205;
		shadow_reg[REG_DECAY_LENGTH] = 4410;
		shadow_reg[REG_RELEASE_LENGTH] = 6615;
		shadow_reg[REG_SUSTAIN_LEVEL] = 22938;
		shadow_reg[REG_MELODY_AMPLITUDE] = 8000;
		shadow_reg[REG_HARMONY_AMPLITUDE] = 6000;
		note_pos = '0;
		mel_acc = '0;
		har_acc = '0;

		// directed script
		// first tick after reset sits at the very start of the attack, so silent
		tick_row(32'h0, 32'h0, 1'b1, 1'b1, 16'sd0, 1'b0);
		tick_row(32'hffff_ffff, 32'hffff_ffff, 1'b0, 1'b0, 16'sd0, 1'b0);
		tick_row(32'h4000_0000, 32'h8000_0001, 1'b0, 1'b0, 16'sd0, 1'b0);
		// three-sample note with no attack, decay or release and a sustain above one
		cfg_row(REG_NOTE_LENGTH, 20'd3);
		cfg_row(REG_ATTACK_LENGTH, 20'd0);
		cfg_row(REG_DECAY_LENGTH, 20'd0);
		cfg_row(REG_RELEASE_LENGTH, 20'd0);
		cfg_row(REG_SUSTAIN_LEVEL, 20'hfffff);
		cfg_row(REG_MELODY_AMPLITUDE, 20'h3fff);
		cfg_row(REG_HARMONY_AMPLITUDE, 20'h3fff);
		tick_row(32'h4000_0000, 32'h4000_0000, 1'b1, 1'b1, 16'sd0, 1'b0);
		// both voices at their positive peak, full volume, near saturation
		tick_row(32'h4000_0000, 32'h4000_0000, 1'b0, 1'b0, 16'sd0, 1'b0);
		// half-turn lands on a zero crossing on the last sample of the note
		tick_row(32'h0, 32'h0, 1'b0, 1'b1, 16'sd0, 1'b1);
		// note over: silence from here
		tick_row(32'h1234_5678, 32'h9abc_def0, 1'b0, 1'b1, 16'sd0, 1'b0);
		// zero note length never sounds
		cfg_row(REG_NOTE_LENGTH, 20'd0);
		tick_row(32'h4000_0000, 32'h4000_0000, 1'b1, 1'b1, 16'sd0, 1'b0);
		// widest stages with zero amplitude; the unused index must do nothing
		cfg_row(REG_NOTE_LENGTH, 20'hfffff);
		cfg_row(REG_ATTACK_LENGTH, 20'hfffff);
		cfg_row(REG_DECAY_LENGTH, 20'hfffff);
		cfg_row(REG_RELEASE_LENGTH, 20'hfffff);
		cfg_row(REG_SUSTAIN_LEVEL, 20'd0);
		cfg_row(REG_MELODY_AMPLITUDE, 20'd0);
		cfg_row(REG_HARMONY_AMPLITUDE, 20'd0);
		cfg_row(REG_UNUSED, 20'hfffff);
		tick_row(32'h4000_0000, 32'hc000_0000, 1'b1, 1'b1, 16'sd0, 1'b0);
		// short note, zero release, ends mid-sustain
		cfg_row(REG_NOTE_LENGTH, 20'd6);
		cfg_row(REG_ATTACK_LENGTH, 20'd2);
		cfg_row(REG_DECAY_LENGTH, 20'd2);
		cfg_row(REG_RELEASE_LENGTH, 20'd0);
		cfg_row(REG_SUSTAIN_LEVEL, 20'd32768);
		cfg_row(REG_MELODY_AMPLITUDE, 20'h3fff);
		cfg_row(REG_HARMONY_AMPLITUDE, 20'h2000);
		for (int k = 0; k < 7; k++) begin
			tick_row(32'h0d00_0000 * (k + 1), 32'h3300_0000, k == 0, 1'b0, 16'sd0, 1'b0);
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		in_cfg = 1'b0;
		foreach (script[k]) begin
			if (script[k].is_cfg) begin
				if (!in_cfg) begin
					settle();
					in_cfg = 1'b1;
				end
				write_reg(script[k].idx, script[k].data);
			end else begin
				if (in_cfg) begin
					@(negedge clk);
					cfg_valid <= 1'b0;
					in_cfg = 1'b0;
				end
				send_tick(script[k].tick, script[k].typed, script[k].want);
			end
		end

		// random phases: fresh registers each phase, notes restarted now and then
		for (int phase = 0; phase < 8; phase++) begin
			settle();
			write_reg(REG_NOTE_LENGTH, pick_len() + ($urandom_range(3) == 0 ? 20'd40 : 20'd0));
			write_reg(REG_ATTACK_LENGTH, pick_len());
			write_reg(REG_DECAY_LENGTH, pick_len());
			write_reg(REG_RELEASE_LENGTH, pick_len());
			write_reg(REG_SUSTAIN_LEVEL,
				$urandom_range(3) == 0 ? 20'd32768 : CFG_DATA_W'($urandom()));
			write_reg(REG_MELODY_AMPLITUDE, phase == 1 ? 20'h3fff : CFG_DATA_W'($urandom()));
			write_reg(REG_HARMONY_AMPLITUDE, phase == 1 ? 20'h3fff : CFG_DATA_W'($urandom()));
			if ($urandom_range(1) == 1) begin
				write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
			end
			@(negedge clk);
			cfg_valid <= 1'b0;
			// one phase with no idling on either side
			calm = (phase == 4);
			note_left = 0;
			for (int k = 0; k < 100; k++) begin
				tick.melody_step = $urandom();
				tick.harmony_step = $urandom();
				// restart once the note has had its length plus a little silence
				tick.note_start = (note_left == 0) || ($urandom_range(49) == 0);
				if (tick.note_start) begin
					note_left = shadow_reg[REG_NOTE_LENGTH] > 60
						? $urandom_range(20, 80) : shadow_reg[REG_NOTE_LENGTH] + $urandom_range(0, 4);
				end else begin
					note_left--;
				end
				send_tick(tick, 1'b0, none);
			end
			calm = 1'b0;
		end

		settle();
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// watchdog well beyond the slowest legal run
	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
